### hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file dlrw_checker.sv.
// Each macro takes a label, the clock, the active-low reset and the property terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deadline window check failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deadline window check failed");

`endif

### hw/rtl/dlrw_pkg.sv
`timescale 1ns / 1ps

package dlrw_pkg;

	// Input item function codes
	localparam logic [1:0] FUNC_DATA = 2'd0;
	localparam logic [1:0] FUNC_ACK  = 2'd1;
	localparam logic [1:0] FUNC_NACK = 2'd2;
	localparam logic [1:0] FUNC_TICK = 2'd3;

	// Result kinds
	localparam logic [1:0] KIND_DATA   = 2'd0;
	localparam logic [1:0] KIND_ACKACK = 2'd1;
	localparam logic [1:0] KIND_RESEND = 2'd2;

	localparam logic [47:0] TIME_MAX       = 48'hFFFF_FFFF_FFFF;
	localparam logic [30:0] SEQ_MAX        = 31'h7FFF_FFFF;
	localparam logic [30:0] SEQ_RESET      = 31'd1;
	localparam logic [31:0] HALF_RTT_RESET = 32'd40000;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic data_commit;
		logic ack_commit;
		logic nack_emit;
		logic mod_start;
		logic rd_head;
		logic rd_nack;
		logic head_adv;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [1:0] func;
		logic       nack_in_win;
		logic       mod_done;
		logic       dl_ok;
		logic       head_lt_next;
		logic       slide_hit;
		logic       out_free;
	} sts_t;

	// Saturating 48-bit time plus 32-bit offset
	function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [31:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {17'd0, b};
		return s[48] ? TIME_MAX : s[47:0];
	endfunction

endpackage

### hw/rtl/dlrw_slot_mod.sv
`timescale 1ns / 1ps

// seq mod DEPTH over three stages: reciprocal multiply, back-multiply, correct.
module dlrw_slot_mod #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [30:0]              x,
	output logic                     done,
	output logic [$clog2(DEPTH)-1:0] slot
);

	localparam int SW = $clog2(DEPTH);
	localparam int RW = SW + 1;
	localparam longint unsigned RECIP_L = (64'd1 << 31) / DEPTH;
	localparam logic [30:0] RECIP = 31'(RECIP_L);
	localparam logic [RW-1:0] DEPTH_RW = RW'(DEPTH);

	logic          v_s1, v_s2, v_s3;
	logic [30:0]   x_s1;
	logic [30:0]   q_s1;
	logic [RW-1:0] r_s2;
	logic [SW-1:0] slot_s3;
	logic [61:0]   prod;
	logic [2*RW-1:0] qd_full;

	// quotient estimate is exact or one low, so the remainder stays below 2*DEPTH
	assign prod    = {31'd0, x} * {31'd0, RECIP};
	assign qd_full = {{RW{1'b0}}, q_s1[RW-1:0]} * {{RW{1'b0}}, DEPTH_RW};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= x;
		q_s1    <= prod[61:31];
		r_s2    <= x_s1[RW-1:0] - qd_full[RW-1:0];
		slot_s3 <= (r_s2 >= DEPTH_RW) ? SW'(r_s2 - DEPTH_RW) : SW'(r_s2);
	end

	assign done = v_s3;
	assign slot = slot_s3;

endmodule

### hw/rtl/dlrw_dpath.sv
`timescale 1ns / 1ps

module dlrw_dpath #(
	parameter int WINDOW_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dlrw_pkg::cmd_t     cmd,
	output dlrw_pkg::sts_t     sts,
	input  logic               cfg_wr_en,
	input  logic [31:0]        cfg_wr_data,
	input  logic [1:0]         func,
	input  logic [47:0]        now_us,
	input  logic [31:0]        payload_tag,
	input  logic signed [31:0] nack_seq,
	input  logic [31:0]        new_half_rtt_us,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [1:0]         kind,
	output logic [30:0]        out_seq,
	output logic [31:0]        out_tag,
	output logic [47:0]        stamp_us
);

	localparam int SW = $clog2(WINDOW_DEPTH);
	localparam logic [SW-1:0] SLOT_LAST  = SW'(WINDOW_DEPTH - 1);
	localparam logic [SW-1:0] SLOT_RESET = SW'(1);

	// captured transaction
	logic [1:0]  func_q;
	logic [47:0] now_q;
	logic [31:0] tag_q;
	logic [31:0] nack_q;
	logic [31:0] nhr_q;

	logic [31:0]   lat_q;
	logic [31:0]   half_rtt_q;
	logic [30:0]   next_seq_q;
	logic [SW-1:0] next_slot_q;
	logic [30:0]   head_q;
	logic [SW-1:0] head_slot_q;

	logic [47:0] dl_mem [WINDOW_DEPTH];
	logic [31:0] tag_mem [WINDOW_DEPTH];
	logic [47:0] rd_dl_q;
	logic [31:0] rd_tag_q;

	logic          out_valid_q;
	logic          load;
	logic          rd_en;
	logic [SW-1:0] rd_addr;
	logic          mod_done;
	logic [SW-1:0] mod_slot;

	// slot follows its sequence number; a wrap of the sequence restarts at slot zero
	function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] sl, input logic [30:0] seq);
		return (seq == dlrw_pkg::SEQ_MAX) ? '0 : ((sl == SLOT_LAST) ? '0 : sl + SW'(1));
	endfunction

	dlrw_slot_mod #(
		.DEPTH(WINDOW_DEPTH)
	) u_slot_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.mod_start),
		.x     (nack_q[30:0]),
		.done  (mod_done),
		.slot  (mod_slot)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			now_q  <= now_us;
			tag_q  <= payload_tag;
			nack_q <= $unsigned(nack_seq);
			nhr_q  <= new_half_rtt_us;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_q       <= '0;
			half_rtt_q  <= dlrw_pkg::HALF_RTT_RESET;
			next_seq_q  <= dlrw_pkg::SEQ_RESET;
			next_slot_q <= SLOT_RESET;
			head_q      <= dlrw_pkg::SEQ_RESET;
			head_slot_q <= SLOT_RESET;
		end else begin
			if (cfg_wr_en) begin
				lat_q <= cfg_wr_data;
			end
			if (cmd.ack_commit) begin
				half_rtt_q <= nhr_q;
			end
			if (cmd.data_commit) begin
				next_seq_q  <= next_seq_q + 31'd1;
				next_slot_q <= slot_inc(next_slot_q, next_seq_q);
			end
			if (cmd.head_adv) begin
				head_q      <= head_q + 31'd1;
				head_slot_q <= slot_inc(head_slot_q, head_q);
			end
		end
	end

	assign rd_en   = cmd.rd_head | cmd.rd_nack;
	assign rd_addr = cmd.rd_nack ? mod_slot : head_slot_q;

	always_ff @(posedge clk) begin
		if (cmd.data_commit) begin
			dl_mem[next_slot_q]  <= dlrw_pkg::sat_add48(now_q, lat_q);
			tag_mem[next_slot_q] <= tag_q;
		end
		if (rd_en) begin
			rd_dl_q  <= dl_mem[rd_addr];
			rd_tag_q <= tag_mem[rd_addr];
		end
	end

	// output register
	assign load = cmd.data_commit | cmd.ack_commit | cmd.nack_emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.data_commit) begin
			kind     <= dlrw_pkg::KIND_DATA;
			out_seq  <= next_seq_q;
			out_tag  <= tag_q;
			stamp_us <= now_q;
		end else if (cmd.ack_commit) begin
			kind     <= dlrw_pkg::KIND_ACKACK;
			out_seq  <= '0;
			out_tag  <= '0;
			stamp_us <= now_q;
		end else if (cmd.nack_emit) begin
			kind     <= dlrw_pkg::KIND_RESEND;
			out_seq  <= nack_q[30:0];
			out_tag  <= rd_tag_q;
			stamp_us <= now_q;
		end
	end

	assign result_valid = out_valid_q;

	always_comb begin
		sts.func         = func_q;
		sts.nack_in_win  = !nack_q[31] && (nack_q[30:0] >= head_q) && (nack_q[30:0] < next_seq_q);
		sts.mod_done     = mod_done;
		sts.dl_ok        = rd_dl_q >= now_q;
		sts.head_lt_next = head_q < next_seq_q;
		sts.slide_hit    = now_q >= dlrw_pkg::sat_add48(rd_dl_q, half_rtt_q);
		sts.out_free     = !out_valid_q || !result_stall;
	end

endmodule

### hw/rtl/dlrw_ctrl.sv
`timescale 1ns / 1ps

module dlrw_ctrl #(
	parameter int WINDOW_DEPTH = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  dlrw_pkg::sts_t sts,
	output dlrw_pkg::cmd_t cmd
);

	localparam int CW = $clog2(WINDOW_DEPTH + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(WINDOW_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_NMOD,
		ST_NCHK,
		ST_SRD,
		ST_SCHK
	} state_t;

	state_t        state_q, state_nxt;
	logic [CW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_EXEC) begin
				cnt_q <= '0;
			end else if (cmd.head_adv) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	assign item_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (sts.func)
					dlrw_pkg::FUNC_DATA: begin
						if (sts.out_free) begin
							cmd.data_commit = 1'b1;
							state_nxt       = ST_SRD;
						end
					end
					dlrw_pkg::FUNC_ACK: begin
						if (sts.out_free) begin
							cmd.ack_commit = 1'b1;
							state_nxt      = ST_SRD;
						end
					end
					dlrw_pkg::FUNC_NACK: begin
						if (sts.nack_in_win) begin
							cmd.mod_start = 1'b1;
							state_nxt     = ST_NMOD;
						end else begin
							state_nxt = ST_SRD;
						end
					end
					default: begin
						state_nxt = ST_SRD;
					end
				endcase
			end
			ST_NMOD: begin
				if (sts.mod_done) begin
					cmd.rd_nack = 1'b1;
					state_nxt   = ST_NCHK;
				end
			end
			ST_NCHK: begin
				if (!sts.dl_ok) begin
					state_nxt = ST_SRD;
				end else if (sts.out_free) begin
					cmd.nack_emit = 1'b1;
					state_nxt     = ST_SRD;
				end
			end
			ST_SRD: begin
				if (sts.head_lt_next && (cnt_q < CNT_MAX)) begin
					cmd.rd_head = 1'b1;
					state_nxt   = ST_SCHK;
				end else begin
					state_nxt = ST_IDLE;
				end
			end
			ST_SCHK: begin
				if (sts.slide_hit) begin
					cmd.head_adv = 1'b1;
					state_nxt    = ST_SRD;
				end else begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

### hw/rtl/deadline_retransmit_window.sv
`timescale 1ns / 1ps

// Sender-side retransmission window for a real-time stream with a delivery deadline.
// Take one transaction at a time on the item channel: a data item stores its payload
// tag and deadline (now_us + latency_window_us, saturating) in slot seq mod WINDOW_DEPTH
// and sends a data packet; an ack item replaces the half round-trip time and sends an
// ack-ack; a NACK item resends the stored tag if the sequence lies in the window and its
// deadline has not passed; a tick only lets the window slide. After every item the head
// advances while now_us >= deadline + half_rtt, never past the next sequence number and
// at most WINDOW_DEPTH slots. Each slot the head advances takes one registered read of
// the deadline memory, then one saturating add and compare. A NACK in the window first
// passes a three-stage reciprocal-multiply slot reduction and the memory read. A result
// waiting on a stalled output register holds the item in progress until the register
// frees. The stores come up undefined and need no clearing pass; the user must write
// latency_window_us through cfg_wr_en/cfg_wr_data only while the block is idle, and
// the block itself does not enforce this.
module deadline_retransmit_window #(
	parameter int WINDOW_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [31:0]        cfg_wr_data,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         func,
	input  logic [47:0]        now_us,
	input  logic [31:0]        payload_tag,
	input  logic signed [31:0] nack_seq,
	input  logic [31:0]        new_half_rtt_us,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [1:0]         kind,
	output logic [30:0]        out_seq,
	output logic [31:0]        out_tag,
	output logic [47:0]        stamp_us
);

	dlrw_pkg::cmd_t cmd;
	dlrw_pkg::sts_t sts;

	// sequence the item: execute, optional NACK lookup, then slide the head
	dlrw_ctrl #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// window state, tag and deadline memories, output register
	dlrw_dpath #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.func           (func),
		.now_us         (now_us),
		.payload_tag    (payload_tag),
		.nack_seq       (nack_seq),
		.new_half_rtt_us(new_half_rtt_us),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.kind           (kind),
		.out_seq        (out_seq),
		.out_tag        (out_tag),
		.stamp_us       (stamp_us)
	);

endmodule

### hw/rtl/dlrw_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dlrw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_stall,
	input logic        result_valid,
	input logic        result_stall,
	input logic [1:0]  kind,
	input logic [30:0] out_seq,
	input logic [31:0] out_tag
);

	// a stalled result is not withdrawn
	`ASSERT_NEXT(a_result_held, clk, arst_n, result_valid && result_stall, result_valid)

	// one item at a time: an accepted transaction stalls the item channel next cycle
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, item_valid && !item_stall, item_stall)

	// a fresh result only comes out of an item in progress
	`ASSERT_IMPLY(a_result_from_item, clk, arst_n, $rose(result_valid), $past(item_stall))

	// an ack-ack carries no sequence number or tag
	`ASSERT_IMPLY(a_ackack_clean, clk, arst_n, result_valid && (kind == dlrw_pkg::KIND_ACKACK), (out_seq == 31'd0) && (out_tag == 32'd0))

endmodule

bind deadline_retransmit_window dlrw_checker u_dlrw_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_stall  (item_stall),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.kind        (kind),
	.out_seq     (out_seq),
	.out_tag     (out_tag)
);

### tb/tb_deadline_retransmit_window.sv
`timescale 1ns / 1ps

module tb_deadline_retransmit_window;

	localparam int WIN_DEPTH     = 64;
	// Worst tail after the last result: one item sliding a full window plus a NACK lookup.
	localparam int SETTLE_CYCLES = 200;
	localparam int N_PHASES      = 12;
	localparam int PHASE_ITEMS   = 78;
	localparam int HOLD_CYCLES   = 400;
	localparam logic [31:0] NACK_EMPTY = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]  op;
		logic [47:0] now;
		logic [31:0] tag;
		logic [31:0] nack;
		logic [31:0] nhr;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [30:0] seq;
		logic [31:0] tag;
		logic [47:0] stamp;
	} packet_t;

	typedef struct {
		item_t   item;
		bit      typed;
		bit      has_pkt;
		packet_t pkt;
	} row_t;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC,
		STALL_BURSTY
	} stall_mode_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic [31:0]        cfg_wr_data = '0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic [1:0]         func = '0;
	logic [47:0]        now_us = '0;
	logic [31:0]        payload_tag = '0;
	logic signed [31:0] nack_seq = '0;
	logic [31:0]        new_half_rtt_us = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic [1:0]         kind;
	logic [30:0]        out_seq;
	logic [31:0]        out_tag;
	logic [47:0]        stamp_us;

	deadline_retransmit_window #(
		.WINDOW_DEPTH(WIN_DEPTH)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.func           (func),
		.now_us         (now_us),
		.payload_tag    (payload_tag),
		.nack_seq       (nack_seq),
		.new_half_rtt_us(new_half_rtt_us),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.kind           (kind),
		.out_seq        (out_seq),
		.out_tag        (out_tag),
		.stamp_us       (stamp_us)
	);

	always #5 clk = ~clk;

	// Shadow of the block's window: stores, sequence pointers, round-trip and latency.
	logic [31:0] tag_copy [WIN_DEPTH];
	logic [47:0] deadline_copy [WIN_DEPTH];
	logic [30:0] win_next;
	logic [30:0] win_head;
	logic [31:0] pred_half_rtt;
	logic [31:0] pred_latency;

	packet_t pending_packets [$];
	packet_t next_want;

	int mismatches = 0;
	int n_data = 0;
	int n_ackack = 0;
	int n_resend = 0;
	int n_silent = 0;
	int n_items = 0;
	int n_settings = 0;

	stall_mode_t stall_mode = STALL_LIGHT;
	int hold_left = 0;
	int cyc = 0;

	function automatic logic [47:0] time_plus(input logic [47:0] a, input logic [31:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {17'd0, b};
		if (s > {1'b0, dlrw_pkg::TIME_MAX})
			return dlrw_pkg::TIME_MAX;
		return s[47:0];
	endfunction

	function automatic int slot_index(input logic [30:0] seq);
		return int'(seq % WIN_DEPTH);
	endfunction

	// Apply one transaction to the shadow window; return 1 when a packet goes out.
	function automatic bit advance_window(input item_t it, output packet_t pkt);
		bit emitted;
		int s;
		int n;
		emitted = 1'b0;
		pkt = '0;
		case (it.op)
			dlrw_pkg::FUNC_DATA: begin
				s = slot_index(win_next);
				tag_copy[s] = it.tag;
				deadline_copy[s] = time_plus(it.now, pred_latency);
				pkt = {dlrw_pkg::KIND_DATA, win_next, it.tag, it.now};
				emitted = 1'b1;
				win_next = win_next + 31'd1;
			end
			dlrw_pkg::FUNC_ACK: begin
				pred_half_rtt = it.nhr;
				pkt = {dlrw_pkg::KIND_ACKACK, 31'd0, 32'd0, it.now};
				emitted = 1'b1;
			end
			dlrw_pkg::FUNC_NACK: begin
				// Negative entries and anything outside [head, next) are dropped.
				if (!it.nack[31] && it.nack[30:0] >= win_head && it.nack[30:0] < win_next) begin
					s = slot_index(it.nack[30:0]);
					if (deadline_copy[s] >= it.now) begin
						pkt = {dlrw_pkg::KIND_RESEND, it.nack[30:0], tag_copy[s], it.now};
						emitted = 1'b1;
					end
				end
			end
			default: ;
		endcase
		// Slide the head over expired slots, bounded by next_seq and one window per item.
		for (n = 0; n < WIN_DEPTH; n++) begin
			if (win_head >= win_next)
				break;
			if (it.now < time_plus(deadline_copy[slot_index(win_head)], pred_half_rtt))
				break;
			win_head = win_head + 31'd1;
		end
		return emitted;
	endfunction

	function automatic item_t mk_item(input logic [1:0] op, input logic [47:0] now,
			input logic [31:0] tag, input logic [31:0] nack, input logic [31:0] nhr);
		return {op, now, tag, nack, nhr};
	endfunction

	function automatic packet_t mk_pkt(input logic [1:0] k, input logic [30:0] seq,
			input logic [31:0] tag, input logic [47:0] stamp);
		return {k, seq, tag, stamp};
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch at %0t ns: %s got %0h want %0h", $time, what, got, want);
		mismatches++;
	endtask

	// Present one transaction and hold it until the block takes it, then predict.
	task automatic offer_item(input item_t it, output bit has, output packet_t pkt);
		item_valid <= 1'b1;
		func <= it.op;
		now_us <= it.now;
		payload_tag <= it.tag;
		nack_seq <= it.nack;
		new_half_rtt_us <= it.nhr;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		has = advance_window(it, pkt);
		if (!has)
			n_silent++;
		n_items++;
	endtask

	// Drop valid, wait for every pending packet, then let any tick-only work finish.
	task automatic drain_block();
		item_valid <= 1'b0;
		while (pending_packets.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_latency(input logic [31:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		pred_latency = v;
		n_settings++;
	endtask

	row_t plan [$];

	task automatic add_row(input item_t it, input bit typed, input bit has,
			input packet_t pkt);
		row_t r;
		r.item = it;
		r.typed = typed;
		r.has_pkt = has;
		r.pkt = pkt;
		plan.push_back(r);
	endtask

	// Receiver: a long hold-off when asked for, otherwise the stall pattern of the phase.
	always @(posedge clk) begin
		cyc++;
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left--;
		end else begin
			case (stall_mode)
				STALL_NONE:     result_stall <= 1'b0;
				STALL_LIGHT:    result_stall <= ($urandom_range(9, 0) < 3);
				STALL_HEAVY:    result_stall <= ($urandom_range(9, 0) < 7);
				STALL_PERIODIC: result_stall <= ((cyc % 7) < 3);
				default:        result_stall <= ((cyc % 64) < 20);
			endcase
		end
	end

	// Compare every accepted result with the oldest pending packet.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_packets.size() == 0) begin
				report_mismatch("result with nothing pending, stamp", 64'(stamp_us), 64'd0);
			end else begin
				next_want = pending_packets.pop_front();
				if (kind !== next_want.kind)
					report_mismatch("kind", 64'(kind), 64'(next_want.kind));
				if (out_seq !== next_want.seq)
					report_mismatch("out_seq", 64'(out_seq), 64'(next_want.seq));
				if (out_tag !== next_want.tag)
					report_mismatch("out_tag", 64'(out_tag), 64'(next_want.tag));
				if (stamp_us !== next_want.stamp)
					report_mismatch("stamp_us", 64'(stamp_us), 64'(next_want.stamp));
				case (next_want.kind)
					dlrw_pkg::KIND_DATA:   n_data++;
					dlrw_pkg::KIND_ACKACK: n_ackack++;
					default:               n_resend++;
				endcase
			end
		end
	end

	initial begin : stimulus
		item_t       it;
		packet_t     pkt;
		bit          has;
		int          ph;
		int          counted;
		int          burst;
		int          pick;
		int          roll;
		int          sel;
		int          gap;
		int unsigned step_max;
		logic [31:0] lat;
		logic [47:0] cursor;
		logic [30:0] span;
		bit          no_idle;

		win_next = dlrw_pkg::SEQ_RESET;
		win_head = dlrw_pkg::SEQ_RESET;
		pred_half_rtt = dlrw_pkg::HALF_RTT_RESET;
		pred_latency = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		write_latency(32'd100000);

		// Directed table. Deadlines below are send time + 100000 us.
		// Tick on an empty window at time zero.
		add_row(mk_item(dlrw_pkg::FUNC_TICK, 48'd0, 32'd0, 32'd0, 32'd0), 1'b1, 1'b0, '0);
		// Three sends; tag extremes.
		add_row(mk_item(dlrw_pkg::FUNC_DATA, 48'd1000, 32'hFFFF_FFFF, 32'd0, 32'd0),
			1'b1, 1'b1, mk_pkt(dlrw_pkg::KIND_DATA, 31'd1, 32'hFFFF_FFFF, 48'd1000));
		add_row(mk_item(dlrw_pkg::FUNC_DATA, 48'd1010, 32'd0, 32'd0, 32'd0), 1'b1, 1'b1,
			mk_pkt(dlrw_pkg::KIND_DATA, 31'd2, 32'd0, 48'd1010));
		add_row(mk_item(dlrw_pkg::FUNC_DATA, 48'd1020, 32'hA5A5_A5A5, 32'd0, 32'd0),
			1'b0, 1'b0, '0);
		// Empty entry, other negative, below head, at next_seq, far above: all dropped.
		add_row(mk_item(dlrw_pkg::FUNC_NACK, 48'd1030, 32'd0, NACK_EMPTY, 32'd0),
			1'b1, 1'b0, '0);
		add_row(mk_item(dlrw_pkg::FUNC_NACK, 48'd1030, 32'd0, 32'h8000_0005, 32'd0),
			1'b1, 1'b0, '0);
		add_row(mk_item(dlrw_pkg::FUNC_NACK, 48'd1030, 32'd0, 32'd0, 32'd0), 1'b1, 1'b0, '0);
		add_row(mk_item(dlrw_pkg::FUNC_NACK, 48'd1030, 32'd0, 32'd4, 32'd0), 1'b1, 1'b0, '0);
		add_row(mk_item(dlrw_pkg::FUNC_NACK, 48'd1030, 32'd0, 32'h7FFF_FFFF, 32'd0),
			1'b1, 1'b0, '0);
		// In-window resend.
		add_row(mk_item(dlrw_pkg::FUNC_NACK, 48'd1040, 32'd0, 32'd2, 32'd0), 1'b1, 1'b1,
			mk_pkt(dlrw_pkg::KIND_RESEND, 31'd2, 32'd0, 48'd1040));
		// Zero half round-trip.
		add_row(mk_item(dlrw_pkg::FUNC_ACK, 48'd1050, 32'd0, 32'd0, 32'd0), 1'b1, 1'b1,
			mk_pkt(dlrw_pkg::KIND_ACKACK, 31'd0, 32'd0, 48'd1050));
		// Resend exactly at the deadline; the head then slides past it.
		add_row(mk_item(dlrw_pkg::FUNC_NACK, 48'd101000, 32'd0, 32'd1, 32'd0), 1'b1, 1'b1,
			mk_pkt(dlrw_pkg::KIND_RESEND, 31'd1, 32'hFFFF_FFFF, 48'd101000));
		add_row(mk_item(dlrw_pkg::FUNC_NACK, 48'd101000, 32'd0, 32'd1, 32'd0),
			1'b1, 1'b0, '0);
		// One microsecond past the deadline.
		add_row(mk_item(dlrw_pkg::FUNC_NACK, 48'd101011, 32'd0, 32'd2, 32'd0),
			1'b1, 1'b0, '0);
		// Tick at the top of time empties the window up to next_seq.
		add_row(mk_item(dlrw_pkg::FUNC_TICK, dlrw_pkg::TIME_MAX, 32'd0, 32'd0, 32'd0),
			1'b1, 1'b0, '0);
		add_row(mk_item(dlrw_pkg::FUNC_ACK, dlrw_pkg::TIME_MAX, 32'd0, 32'd0, 32'hFFFF_FFFF),
			1'b1, 1'b1, mk_pkt(dlrw_pkg::KIND_ACKACK, 31'd0, 32'd0, dlrw_pkg::TIME_MAX));
		// Saturating deadline, then a resend at the top of time.
		add_row(mk_item(dlrw_pkg::FUNC_DATA, dlrw_pkg::TIME_MAX - 48'd5, 32'h1234_5678,
			32'd0, 32'd0), 1'b1, 1'b1,
			mk_pkt(dlrw_pkg::KIND_DATA, 31'd4, 32'h1234_5678, dlrw_pkg::TIME_MAX - 48'd5));
		add_row(mk_item(dlrw_pkg::FUNC_NACK, dlrw_pkg::TIME_MAX, 32'd0, 32'd4, 32'd0),
			1'b1, 1'b1,
			mk_pkt(dlrw_pkg::KIND_RESEND, 31'd4, 32'h1234_5678, dlrw_pkg::TIME_MAX));
		add_row(mk_item(dlrw_pkg::FUNC_NACK, dlrw_pkg::TIME_MAX, 32'd0, 32'd4, 32'd0),
			1'b1, 1'b0, '0);
		// Time going back, half round-trip restored.
		add_row(mk_item(dlrw_pkg::FUNC_ACK, 48'd2000, 32'd0, 32'd0, 32'd40000),
			1'b0, 1'b0, '0);

		foreach (plan[i]) begin
			offer_item(plan[i].item, has, pkt);
			if (plan[i].typed) begin
				if (plan[i].has_pkt)
					pending_packets.push_back(plan[i].pkt);
			end else if (has) begin
				pending_packets.push_back(pkt);
			end
		end
		drain_block();

		// Random phases: one latency setting, time base and stall pattern each.
		for (ph = 0; ph < N_PHASES; ph++) begin
			case (ph % 6)
				0:       lat = 32'd100000;
				1:       lat = 32'd0;
				2:       lat = 32'hFFFF_FFFF;
				3:       lat = $urandom;
				4:       lat = $urandom_range(20000, 1000);
				default: lat = $urandom_range(300000, 50000);
			endcase
			write_latency(lat);
			// Every fourth phase runs near the top of time to hit saturation.
			if (ph % 4 == 3)
				cursor = dlrw_pkg::TIME_MAX - 48'($urandom_range(2000000, 0));
			else
				cursor = 48'({$urandom, $urandom});
			case (ph % 3)
				0:       step_max = 2000;
				1:       step_max = 200;
				default: step_max = 20000;
			endcase
			stall_mode = stall_mode_t'(ph % 5);
			no_idle = (ph % 4 == 1) || (ph == 2) || (ph == 8);
			// Hold the output long enough to back the block up into its input.
			if (ph == 2 || ph == 8)
				hold_left = HOLD_CYCLES;

			counted = 0;
			while (counted < PHASE_ITEMS) begin
				burst = $urandom_range(24, 1);
				if (burst > PHASE_ITEMS - counted)
					burst = PHASE_ITEMS - counted;
				repeat (burst) begin
					pick = $urandom_range(99, 0);
					if (pick < 40)
						it.op = dlrw_pkg::FUNC_DATA;
					else if (pick < 75)
						it.op = dlrw_pkg::FUNC_NACK;
					else if (pick < 83)
						it.op = dlrw_pkg::FUNC_ACK;
					else
						it.op = dlrw_pkg::FUNC_TICK;

					// Advance time mostly in small steps, now and then a big jump.
					roll = $urandom_range(99, 0);
					if (roll < 2)
						cursor = time_plus(cursor, 32'($urandom_range(500000, 0)));
					else
						cursor = time_plus(cursor, 32'($urandom_range(step_max, 0)));
					it.now = cursor;
					if (roll == 99)
						it.now = 48'({$urandom, $urandom});
					else if (it.op == dlrw_pkg::FUNC_TICK && roll >= 95)
						it.now = dlrw_pkg::TIME_MAX;

					it.tag = $urandom;

					sel = $urandom_range(19, 0);
					if (sel == 0)
						it.nhr = 32'd0;
					else if (sel == 1)
						it.nhr = 32'hFFFF_FFFF;
					else if (sel < 4)
						it.nhr = $urandom;
					else
						it.nhr = $urandom_range(60000, 0);

					// Aim most NACKs inside the live window, the rest at its edges or noise.
					span = win_next - win_head;
					sel = $urandom_range(99, 0);
					if (span != 0 && sel < 65)
						it.nack = {1'b0, win_head + 31'($urandom_range(span - 1, 0))};
					else if (sel < 72)
						it.nack = NACK_EMPTY;
					else if (sel < 78)
						it.nack = {1'b1, 31'($urandom)};
					else if (sel < 85)
						it.nack = {1'b0, win_head - 31'($urandom_range(3, 1))};
					else if (sel < 92)
						it.nack = {1'b0, win_next + 31'($urandom_range(3, 0))};
					else
						it.nack = {1'b0, 31'($urandom)};

					offer_item(it, has, pkt);
					if (has)
						pending_packets.push_back(pkt);
					counted++;
				end
				if (!no_idle) begin
					gap = ($urandom_range(99, 0) < 10) ? $urandom_range(40, 7)
						: $urandom_range(6, 1);
					item_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			drain_block();
		end

		if (pending_packets.size() != 0)
			report_mismatch("packets never delivered", 64'(pending_packets.size()), 64'd0);

		$display("covered %0d items over %0d latency settings: %0d data, %0d ack-ack, %0d resends",
			n_items, n_settings, n_data, n_ackack, n_resend);
		$display("%0d items left no result; window ended at head %0d, next %0d",
			n_silent, win_head, win_next);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Watchdog well beyond the slowest legal run.
	initial begin
		#20_000_000;
		$display("timeout: block stopped responding");
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
